>>> src/rpdo_pkg.sv
// Package for the random pixel dissolve order block: sizes, codes and transaction types.
`timescale 1ns / 1ps

package rpdo_pkg;

   // Largest frame side; every table and counter width follows from it.
   localparam int MAX_SIDE = 512;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int ENTRY_W  = 2 * COORD_W;
   localparam int FRAC_W   = 32;
   localparam int PROD_W   = ADDR_W + FRAC_W;

   // Fixed field widths of the interface.
   localparam int CFG_W = 10;
   localparam int XY_W  = 9;

   localparam logic [CFG_W-1:0] FRAME_SIDE_RESET = 10'd512;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      FUNC_RESTART = 1'b0,
      FUNC_DRAW    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DRAWN   = 2'd0,
      STATUS_RESTART = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FILL,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      func_type          func;
      logic [FRAC_W-1:0] rand_fraction;
   } req_data_type;

   typedef struct packed {
      status_type      status;
      logic [XY_W-1:0] pixel_x;
      logic [XY_W-1:0] pixel_y;
      logic            last;
   } rsp_data_type;

endpackage

>>> src/random_pixel_dissolve_order.sv
// Top level of the random pixel dissolve order generator (shuffled coordinate table).
`timescale 1ns / 1ps

// Emits every (x,y) coordinate of a frame exactly once, in a random order, by a
// shuffle over a location table held in an internal memory.
//
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low. A restart transaction (func restart) refills the table in
// raster order and reloads the remaining count with width * height; a draw
// transaction (func draw) picks entry r = (k * rand_fraction) >> 32 with k the
// decremented count, returns its coordinate and moves entry k into slot r.
// Result channel: rsp_valid is high for exactly one cycle per transaction and the
// receiver cannot hold it off. A draw with nothing left gives status "no pixels
// left" in the cycle after acceptance. A normal draw goes through the shared
// multiplier, one memory read of the two entries and one write-back, then the
// registered result; busy is high for these three working steps. A restart
// takes one multiplier step (the area product) and then one table write per
// pixel, with at least one fill step, before its registered result.
// Configuration writes to csr_* take effect at the next restart only. Reset
// clears the remaining count and the state machine; the table itself is not
// cleared, since only entries written by a restart are ever read.
module random_pixel_dissolve_order (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  rpdo_pkg::req_data_type      req_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output rpdo_pkg::rsp_data_type      rsp_data,
   input  logic                        csr_we,
   input  rpdo_pkg::reg_index_type     csr_addr,
   input  logic [rpdo_pkg::CFG_W-1:0]  csr_wdata
);

   // Control state.
   rpdo_pkg::state_type                state_ff, state_in;
   logic [rpdo_pkg::CFG_W-1:0]         width_ff, height_ff;
   logic [rpdo_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rpdo_pkg::rsp_data_type             rsp_data_ff, rsp_data_in;

   // Datapath registers.
   logic                               op_restart_ff;
   logic [rpdo_pkg::ADDR_W-1:0]        opa_ff;
   logic [rpdo_pkg::FRAC_W-1:0]        opb_ff;
   logic [rpdo_pkg::PROD_W-1:0]        prod_ff;
   logic [rpdo_pkg::SIDE_W-1:0]        fill_w_ff, fill_h_ff;
   logic [rpdo_pkg::COORD_W-1:0]       x_ff, y_ff;
   logic [rpdo_pkg::ADDR_W-1:0]        fill_addr_ff;
   logic [rpdo_pkg::ENTRY_W-1:0]       rd_r_ff, rd_k_ff;

   // Location table: entry holds {y, x}.
   logic [rpdo_pkg::ENTRY_W-1:0]       location_table_ff [rpdo_pkg::DEPTH];

   logic                               mem_we;
   logic [rpdo_pkg::ADDR_W-1:0]        mem_waddr;
   logic [rpdo_pkg::ENTRY_W-1:0]       mem_wdata;

   logic                               accept;
   logic                               is_restart;
   logic [rpdo_pkg::SIDE_W-1:0]        side_w, side_h;
   logic [rpdo_pkg::ADDR_W-1:0]        draw_k;
   logic [rpdo_pkg::ADDR_W-1:0]        r_addr;
   logic [rpdo_pkg::CNT_W-1:0]         area;
   logic                               area_zero;
   logic                               x_last, y_last, fill_done;

   function automatic logic [rpdo_pkg::SIDE_W-1:0] clamp_side(
      input logic [rpdo_pkg::CFG_W-1:0] v);
      if (int'(v) > rpdo_pkg::MAX_SIDE) begin
         return rpdo_pkg::SIDE_W'(rpdo_pkg::MAX_SIDE);
      end
      return rpdo_pkg::SIDE_W'(v);
   endfunction

   assign busy       = (state_ff != rpdo_pkg::ST_IDLE);
   assign accept     = start & ~busy;
   assign is_restart = (req_data.func == rpdo_pkg::FUNC_RESTART);
   assign side_w     = clamp_side(width_ff);
   assign side_h     = clamp_side(height_ff);
   assign draw_k     = rpdo_pkg::ADDR_W'(count_ff - rpdo_pkg::CNT_W'(1));

   // The multiplier's high word is the chosen slot for a draw; its low bits are
   // the frame area for a restart.
   assign r_addr    = prod_ff[rpdo_pkg::FRAC_W +: rpdo_pkg::ADDR_W];
   assign area      = prod_ff[rpdo_pkg::CNT_W-1:0];
   assign area_zero = (area == '0);

   assign x_last    = ((rpdo_pkg::SIDE_W'(x_ff) + rpdo_pkg::SIDE_W'(1)) == fill_w_ff);
   assign y_last    = ((rpdo_pkg::SIDE_W'(y_ff) + rpdo_pkg::SIDE_W'(1)) == fill_h_ff);
   assign fill_done = area_zero | (x_last & y_last);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpdo_pkg::ST_IDLE: begin
            if (accept && (is_restart || count_ff != '0)) begin
               state_in = rpdo_pkg::ST_MUL;
            end
         end
         rpdo_pkg::ST_MUL: begin
            state_in = op_restart_ff ? rpdo_pkg::ST_FILL : rpdo_pkg::ST_READ;
         end
         rpdo_pkg::ST_FILL: begin
            if (fill_done) begin
               state_in = rpdo_pkg::ST_IDLE;
            end
         end
         rpdo_pkg::ST_READ: begin
            state_in = rpdo_pkg::ST_WRITE;
         end
         rpdo_pkg::ST_WRITE: begin
            state_in = rpdo_pkg::ST_IDLE;
         end
         default: begin
            state_in = rpdo_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: table write port, result and remaining count.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = {y_ff, x_ff};
      count_in     = count_ff;
      unique case (state_ff)
         rpdo_pkg::ST_IDLE: begin
            // A draw with an empty table answers at once and changes nothing.
            if (accept && !is_restart && count_ff == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = rpdo_pkg::STATUS_EMPTY;
            end
         end
         rpdo_pkg::ST_FILL: begin
            mem_we = ~area_zero;
            if (fill_done) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = rpdo_pkg::STATUS_RESTART;
               count_in           = area;
            end
         end
         rpdo_pkg::ST_WRITE: begin
            // Entry k moves into slot r; entry r goes out as the result.
            mem_we              = 1'b1;
            mem_waddr           = r_addr;
            mem_wdata           = rd_k_ff;
            rsp_valid_in        = 1'b1;
            rsp_data_in.status  = rpdo_pkg::STATUS_DRAWN;
            rsp_data_in.pixel_x = rpdo_pkg::XY_W'(rd_r_ff[rpdo_pkg::COORD_W-1:0]);
            rsp_data_in.pixel_y = rpdo_pkg::XY_W'(
               rd_r_ff[rpdo_pkg::ENTRY_W-1:rpdo_pkg::COORD_W]);
            rsp_data_in.last    = (opa_ff == '0);
            count_in            = rpdo_pkg::CNT_W'(opa_ff);
         end
         rpdo_pkg::ST_MUL, rpdo_pkg::ST_READ: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpdo_pkg::ST_IDLE;
         count_ff     <= '0;
         width_ff     <= rpdo_pkg::FRAME_SIDE_RESET;
         height_ff    <= rpdo_pkg::FRAME_SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               rpdo_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
               rpdo_pkg::REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            endcase
         end
      end
   end

   // Datapath registers: operands, the shared multiplier and the fill walk.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         op_restart_ff <= is_restart;
         if (is_restart) begin
            opa_ff       <= rpdo_pkg::ADDR_W'(side_w);
            opb_ff       <= rpdo_pkg::FRAC_W'(side_h);
            fill_w_ff    <= side_w;
            fill_h_ff    <= side_h;
            x_ff         <= '0;
            y_ff         <= '0;
            fill_addr_ff <= '0;
         end else begin
            opa_ff <= draw_k;
            opb_ff <= req_data.rand_fraction;
         end
      end
      if (state_ff == rpdo_pkg::ST_MUL) begin
         prod_ff <= rpdo_pkg::PROD_W'(opa_ff) * rpdo_pkg::PROD_W'(opb_ff);
      end
      if (state_ff == rpdo_pkg::ST_FILL) begin
         fill_addr_ff <= fill_addr_ff + rpdo_pkg::ADDR_W'(1);
         if (x_last) begin
            x_ff <= '0;
            y_ff <= y_ff + rpdo_pkg::COORD_W'(1);
         end else begin
            x_ff <= x_ff + rpdo_pkg::COORD_W'(1);
         end
      end
   end

   // Location table: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         location_table_ff[mem_waddr] <= mem_wdata;
      end
      rd_r_ff <= location_table_ff[r_addr];
      rd_k_ff <= location_table_ff[opa_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/rpdo_checker.sv
// Port-level checker for the random pixel dissolve order block, with its bind.
`timescale 1ns / 1ps

module rpdo_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input rpdo_pkg::req_data_type req_data,
   input logic                   busy,
   input logic                   rsp_valid,
   input rpdo_pkg::rsp_data_type rsp_data
);

   // Reset leaves the block idle with no result on the port.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result or busy after reset");

   // A restart always walks the table, so the block is busy next cycle.
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == rpdo_pkg::FUNC_RESTART) |=> busy)
      else $error("restart transaction did not make the block busy");

   // Only a drawn pixel carries a coordinate or the last flag.
   a_non_draw_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rpdo_pkg::STATUS_DRAWN) |->
      (rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0 && !rsp_data.last))
      else $error("non-draw result carries pixel data");

   // An empty-table answer comes straight after the transaction was taken.
   a_empty_prompt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == rpdo_pkg::STATUS_EMPTY) |->
      $past(start && !busy))
      else $error("empty-table result without a transaction the cycle before");

   // A drawn pixel is only produced after the table read and write-back.
   a_draw_after_work: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == rpdo_pkg::STATUS_DRAWN) |-> $past(busy))
      else $error("drawn pixel result without preceding busy cycle");

endmodule

bind random_pixel_dissolve_order rpdo_checker u_rpdo_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the random pixel dissolve order generator.
`timescale 1ns / 1ps

// The block shuffles a table of frame coordinates: a restart transaction refills
// the table in raster order, and each draw transaction returns one randomly
// chosen coordinate and closes the gap with the entry at the end of the live
// region. This bench keeps its own copy of that table, the remaining count and
// the two frame registers. It works out the result of every accepted command
// transaction at the edge that accepts it, and compares each result transaction
// with the oldest prediction still waiting.
//
// Stimulus runs in two parts. A short directed part covers these cases:
// - a draw before any restart;
// - a full-size frame with extreme fractions;
// - a register change that must not affect the table until the next restart;
// - exhausting a small frame, with the last flag and the draw after it;
// - zero and oversized registers;
// - single-row and single-column frames.
// A random part follows. It is mostly restart-then-drain sequences on small
// frames, with some interrupted sequences and some loose commands mixed in.
module testbench;

   localparam int RANDOM_ITEMS   = 1050;
   // The slowest legal gap between transactions is a full 512 x 512 restart;
   // the watchdog allows about three times that.
   localparam int WATCHDOG_LIMIT = 800_000;

   typedef struct packed {
      logic [rpdo_pkg::XY_W-1:0] y;
      logic [rpdo_pkg::XY_W-1:0] x;
   } pixel_loc_type;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         start     = 1'b0;
   rpdo_pkg::req_data_type       req_data  = '0;
   logic                         busy;
   logic                         rsp_valid;
   rpdo_pkg::rsp_data_type       rsp_data;
   logic                         csr_we    = 1'b0;
   rpdo_pkg::reg_index_type      csr_addr  = rpdo_pkg::REG_FRAME_WIDTH;
   logic [rpdo_pkg::CFG_W-1:0]   csr_wdata = '0;

   // Predictor state: the shuffled coordinate table, the number of pixels still
   // to come, and the frame registers as last written.
   pixel_loc_type                loc_model [0:rpdo_pkg::DEPTH-1];
   logic [rpdo_pkg::CNT_W-1:0]   pixels_left;
   logic [rpdo_pkg::CFG_W-1:0]   frame_w_shadow;
   logic [rpdo_pkg::CFG_W-1:0]   frame_h_shadow;

   rpdo_pkg::req_data_type       pending_cmds [$];
   rpdo_pkg::rsp_data_type       expected_rsps [$];
   int                           sender_idle_pct = 0;
   int                           items_queued    = 0;
   int                           mismatch_count  = 0;
   int                           quiet_cycles    = 0;

   random_pixel_dissolve_order dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A side larger than the table allows is treated as the largest side.
   function automatic int unsigned clamp_side(logic [rpdo_pkg::CFG_W-1:0] side);
      return (side > rpdo_pkg::MAX_SIDE) ? rpdo_pkg::MAX_SIDE : side;
   endfunction

   // Applies one command transaction to the predictor and returns the result
   // that the block must produce for it.
   function automatic rpdo_pkg::rsp_data_type dissolve_step(rpdo_pkg::req_data_type cmd);
      rpdo_pkg::rsp_data_type        res;
      int unsigned                   w;
      int unsigned                   h;
      logic [rpdo_pkg::CNT_W-1:0]    k;
      logic [63:0]                   prod;
      logic [rpdo_pkg::ADDR_W-1:0]   r;
      res = '0;
      if (cmd.func == rpdo_pkg::FUNC_RESTART) begin
         // The frame size is taken from the registers only here, so a register
         // write between restarts leaves the running shuffle alone.
         w = clamp_side(frame_w_shadow);
         h = clamp_side(frame_h_shadow);
         for (int yi = 0; yi < h; yi++) begin
            for (int xi = 0; xi < w; xi++) begin
               loc_model[yi * w + xi] = {rpdo_pkg::XY_W'(yi), rpdo_pkg::XY_W'(xi)};
            end
         end
         pixels_left = rpdo_pkg::CNT_W'(w * h);
         res.status = rpdo_pkg::STATUS_RESTART;
      end else if (pixels_left == 0) begin
         // Nothing left, or no restart yet: the table is not touched.
         res.status = rpdo_pkg::STATUS_EMPTY;
      end else begin
         k     = pixels_left - 1'b1;
         prod  = 64'(k) * 64'(cmd.rand_fraction);
         r     = prod[rpdo_pkg::FRAC_W +: rpdo_pkg::ADDR_W];
         res.status  = rpdo_pkg::STATUS_DRAWN;
         res.pixel_x = loc_model[r].x;
         res.pixel_y = loc_model[r].y;
         res.last    = (k == 0);
         loc_model[r] = loc_model[k[rpdo_pkg::ADDR_W-1:0]];
         pixels_left  = k;
      end
      return res;
   endfunction

   // Driver: a command sits on the port until the block takes it, and the next
   // one may follow straight away, or after a random number of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(dissolve_step(req_data));
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_cmds.pop_front();
               start    <= 1'b1;
            end else begin
               start    <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, logic [rpdo_pkg::XY_W-1:0] want,
                              logic [rpdo_pkg::XY_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Monitor: results cannot be held off, so every strobe is one transaction.
   // The same block keeps the watchdog on accepted transactions of either kind.
   always @(posedge clock) begin : monitor
      rpdo_pkg::rsp_data_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with nothing expected, got %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status",  rpdo_pkg::XY_W'(want.status),
                           rpdo_pkg::XY_W'(rsp_data.status));
               check_field("pixel_x", want.pixel_x, rsp_data.pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_data.pixel_y);
               check_field("last",    rpdo_pkg::XY_W'(want.last),
                           rpdo_pkg::XY_W'(rsp_data.last));
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_cmd(rpdo_pkg::func_type f, logic [rpdo_pkg::FRAC_W-1:0] frac);
      rpdo_pkg::req_data_type cmd;
      cmd.func          = f;
      cmd.rand_fraction = frac;
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   // Fractions lean towards the ends of the range as well as plain random ones.
   function automatic logic [rpdo_pkg::FRAC_W-1:0] pick_fraction();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return rpdo_pkg::FRAC_W'($urandom_range(255));
         3:       return '1 - rpdo_pkg::FRAC_W'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   // Waits until every queued command has been taken, every result has come
   // back and the block has dropped busy. The check runs on the falling edge,
   // when everything the driver did at the rising edge has settled.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0 || busy);
   endtask

   // Register writes happen only while the block is idle; the predictor's copy
   // is updated with them.
   task automatic set_frame(logic [rpdo_pkg::CFG_W-1:0] w, logic [rpdo_pkg::CFG_W-1:0] h);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= rpdo_pkg::REG_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= rpdo_pkg::REG_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we    <= 1'b0;
      frame_w_shadow = w;
      frame_h_shadow = h;
   endtask

   initial begin
      logic [rpdo_pkg::CFG_W-1:0] w;
      logic [rpdo_pkg::CFG_W-1:0] h;
      int                         sel;
      int                         area;
      int                         group_no;
      int                         random_goal;
      int                         idle_phase [3];
      pixels_left    = '0;
      frame_w_shadow = rpdo_pkg::FRAME_SIDE_RESET;
      frame_h_shadow = rpdo_pkg::FRAME_SIDE_RESET;
      idle_phase     = '{0, 65, 37};
      group_no       = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A draw straight after reset finds no pixels. Then the full frame from
      // the reset registers, drawn at both ends of the fraction range.
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);
      queue_cmd(rpdo_pkg::FUNC_RESTART, '0);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '0);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);
      queue_cmd(rpdo_pkg::FUNC_DRAW, 32'h8000_0000);

      // New registers must not change the draws until the next restart.
      set_frame(10'd3, 10'd2);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);
      queue_cmd(rpdo_pkg::FUNC_RESTART, $urandom);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '0);
      repeat (4) queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);

      // A zero side leaves nothing to draw.
      set_frame(10'd0, 10'd5);
      queue_cmd(rpdo_pkg::FUNC_RESTART, '1);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);

      // Oversized sides saturate to the largest side: one full row, then one
      // full column, so the top coordinate bits get exercised.
      set_frame(10'd1023, 10'd1);
      queue_cmd(rpdo_pkg::FUNC_RESTART, '0);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);
      set_frame(10'd1, 10'd1023);
      queue_cmd(rpdo_pkg::FUNC_RESTART, '0);
      queue_cmd(rpdo_pkg::FUNC_DRAW, '1);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);

      // The smallest frame: its only draw is also the last one.
      set_frame(10'd1, 10'd1);
      queue_cmd(rpdo_pkg::FUNC_RESTART, '0);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);
      queue_cmd(rpdo_pkg::FUNC_DRAW, $urandom);
      wait_drained();

      // Random part. The sender's idling changes every three sequences.
      random_goal = items_queued + RANDOM_ITEMS;
      while (items_queued < random_goal) begin
         sender_idle_pct = idle_phase[(group_no / 3) % 3];
         if ($urandom_range(99) < 60) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
               w = rpdo_pkg::CFG_W'($urandom_range(1, 8));
               h = rpdo_pkg::CFG_W'($urandom_range(1, 8));
            end else if (sel < 85) begin
               w = rpdo_pkg::CFG_W'($urandom_range(1, 40));
               h = rpdo_pkg::CFG_W'($urandom_range(1, 40));
            end else if (sel < 93) begin
               w = $urandom_range(1) ? '0 :
                   rpdo_pkg::CFG_W'($urandom_range(rpdo_pkg::MAX_SIDE + 1, 1023));
               h = rpdo_pkg::CFG_W'($urandom_range(1, 6));
            end else begin
               w = rpdo_pkg::CFG_W'($urandom_range(rpdo_pkg::MAX_SIDE / 2 + 1,
                                                   rpdo_pkg::MAX_SIDE));
               h = rpdo_pkg::CFG_W'($urandom_range(1, 2));
            end
            if ($urandom_range(1)) {w, h} = {h, w};
            set_frame(w, h);
         end
         area = clamp_side(frame_w_shadow) * clamp_side(frame_h_shadow);
         sel  = $urandom_range(99);
         if (sel < 75) begin
            // Restart and drain, running past the end now and then. Large
            // frames are only sampled, not drained.
            queue_cmd(rpdo_pkg::FUNC_RESTART, $urandom);
            repeat ((area > 40) ? 40 : area + $urandom_range(2)) begin
               queue_cmd(rpdo_pkg::FUNC_DRAW, pick_fraction());
            end
         end else if (sel < 88) begin
            // A restart cuts a shuffle short.
            queue_cmd(rpdo_pkg::FUNC_RESTART, $urandom);
            repeat ($urandom_range((area > 20) ? 20 : area)) begin
               queue_cmd(rpdo_pkg::FUNC_DRAW, pick_fraction());
            end
            queue_cmd(rpdo_pkg::FUNC_RESTART, $urandom);
            repeat ($urandom_range(1, 6)) queue_cmd(rpdo_pkg::FUNC_DRAW, pick_fraction());
         end else begin
            // Loose commands, mostly draws on whatever is left.
            repeat ($urandom_range(3, 10)) begin
               queue_cmd(($urandom_range(3) == 0) ? rpdo_pkg::FUNC_RESTART
                                                   : rpdo_pkg::FUNC_DRAW,
                         pick_fraction());
            end
         end
         wait_drained();
         group_no++;
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> random_pixel_dissolve_order.f
src/rpdo_pkg.sv
src/random_pixel_dissolve_order.sv
src/rpdo_checker.sv
tb/testbench.sv
